>>> design/ils_pkg.sv
`default_nettype none

package ils_pkg;

  localparam int DEPTH     = 16;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int DW        = 32;
  localparam int FUNC_W    = 4;
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PREPEND  = 4'd0,
    FN_APPEND   = 4'd1,
    FN_DELFIRST = 4'd2,
    FN_DELLAST  = 4'd3,
    FN_GET      = 4'd4,
    FN_SET      = 4'd5,
    FN_INSERT   = 4'd6,
    FN_REMOVE   = 4'd7,
    FN_CLEAR    = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_GET,
    S_HEAD,
    S_TAIL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 valid;
    logic [DW-1:0]        read_value;
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
    logic [DW-1:0]        head_value;
    logic [DW-1:0]        tail_value;
  } result_t;

endpackage

`default_nettype wire

>>> design/indexed_list_store.sv
// Flow: adds and deletes first shift entries where needed, each with S_MV_RD (read) and
//   S_MV_WR (write back); adds and set then write in S_PUT, get reads in S_GET. Every word
//   then passes S_HEAD (head read), S_TAIL (tail read, skipped when the list ends empty), S_FIN.
// Flow control: one word at a time; in_ready_o rises as the result loads into the output
//   register; while that result waits untaken, a second waiting result blocks in S_FIN.
// Reset: rst_ni clears the element count and control; entries are not cleared.
`default_nettype none

module indexed_list_store import ils_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [FUNC_W-1:0]    func_i,
  input  wire logic [POS_W-1:0]     position_i,
  input  wire logic signed [DW-1:0] item_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [DW-1:0]      read_value_o,
  output logic [1:0]                status_o,
  output logic [CNT_OUT_W-1:0]      count_o,
  output logic signed [DW-1:0]      head_value_o,
  output logic signed [DW-1:0]      tail_value_o
);

  mem_req_t      mem_req;
  logic [DW-1:0] rdata;
  result_t       res;
  logic          take;

  logic                 out_valid_q;
  logic [DW-1:0]        read_value_q;
  status_e              status_q;
  logic [CNT_OUT_W-1:0] count_q;
  logic [DW-1:0]        head_value_q;
  logic [DW-1:0]        tail_value_q;

  assign take = res.valid && (!out_valid_q || out_ready_i);

  ils_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .take_i       (take),
    .rdata_i      (rdata),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  ils_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      read_value_q <= res.read_value;
      status_q     <= res.status;
      count_q      <= res.count;
      head_value_q <= res.head_value;
      tail_value_q <= res.tail_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign head_value_o = head_value_q;
  assign tail_value_o = tail_value_q;

endmodule

`default_nettype wire

>>> design/ils_ram.sv
`default_nettype none

module ils_ram import ils_pkg::*; (
  input  wire logic          clk_i,
  input  wire mem_req_t      req_i,
  output logic     [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/ils_ctrl.sv
`default_nettype none

module ils_ctrl import ils_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [DW-1:0]     item_value_i,
  input  wire logic              take_i,
  input  wire logic [DW-1:0]     rdata_i,
  output mem_req_t               mem_req_o,
  output result_t                res_o
);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] lim_q, lim_d;
  logic [AW-1:0] ip_q, ip_d;
  logic          up_q, up_d;
  logic          get_q, get_d;
  status_e       st_q, st_d;
  logic [DW-1:0] val_q, val_d;
  logic [DW-1:0] rd_q, rd_d;
  logic [DW-1:0] head_q, head_d;

  logic          accept;
  logic          empty;
  logic          full;
  logic          pos_ge;
  logic          pos_gt;
  logic [AW-1:0] ipos;
  logic [AW-1:0] tpos;
  logic [AW-1:0] last_idx;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign empty    = (cnt_q == '0);
  assign full     = (int'(cnt_q) >= DEPTH);
  assign pos_ge   = (int'(position_i) >= int'(cnt_q));
  assign pos_gt   = (int'(position_i) > int'(cnt_q));
  assign last_idx = AW'(cnt_q - CW'(1));

  always_comb begin
    unique case (func_e'(func_i))
      FN_PREPEND: ipos = '0;
      FN_APPEND:  ipos = AW'(cnt_q);
      default:    ipos = AW'(position_i);
    endcase
    unique case (func_e'(func_i))
      FN_DELFIRST: tpos = '0;
      FN_DELLAST:  tpos = last_idx;
      default:     tpos = AW'(position_i);
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    ip_d    = ip_q;
    up_d    = up_q;
    get_d   = get_q;
    st_d    = st_q;
    val_d   = val_q;
    rd_d    = rd_q;
    head_d  = head_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ST_OK;
          rd_d    = '0;
          get_d   = 1'b0;
          val_d   = item_value_i;
          state_d = S_HEAD;
          unique case (func_e'(func_i))
            FN_PREPEND, FN_APPEND, FN_INSERT: begin
              if ((func_e'(func_i) == FN_INSERT) && pos_gt) begin
                st_d = ST_OOB;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                cnt_d   = cnt_q + CW'(1);
                ip_d    = ipos;
                up_d    = 1'b1;
                idx_d   = last_idx;
                lim_d   = ipos;
                state_d = (int'(cnt_q) > int'(ipos)) ? S_MV_RD : S_PUT;
              end
            end
            FN_DELFIRST, FN_DELLAST, FN_REMOVE: begin
              if ((func_e'(func_i) != FN_REMOVE) && empty) begin
                st_d = ST_EMPTY;
              end else if ((func_e'(func_i) == FN_REMOVE) && pos_ge) begin
                st_d = ST_OOB;
              end else begin
                cnt_d   = cnt_q - CW'(1);
                up_d    = 1'b0;
                idx_d   = tpos + AW'(1);
                lim_d   = last_idx;
                state_d = (int'(tpos) + 1 < int'(cnt_q)) ? S_MV_RD : S_HEAD;
              end
            end
            FN_GET, FN_SET: begin
              if (empty) begin
                st_d = ST_EMPTY;
              end else if (pos_ge) begin
                st_d = ST_OOB;
              end else begin
                ip_d    = AW'(position_i);
                get_d   = (func_e'(func_i) == FN_GET);
                state_d = (func_e'(func_i) == FN_GET) ? S_GET : S_PUT;
              end
            end
            FN_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MV_RD: begin
        state_d = S_MV_WR;
      end
      S_MV_WR: begin
        if (idx_q == lim_q) begin
          state_d = up_q ? S_PUT : S_HEAD;
        end else begin
          idx_d   = up_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
          state_d = S_MV_RD;
        end
      end
      S_PUT: begin
        state_d = S_HEAD;
      end
      S_GET: begin
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (get_q) begin
          rd_d = rdata_i;
        end
        state_d = empty ? S_FIN : S_TAIL;
      end
      S_TAIL: begin
        head_d  = rdata_i;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = ip_q;
    mem_req_o.wdata = val_q;
    mem_req_o.raddr = idx_q;
    unique case (state_q)
      S_MV_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = up_q ? (idx_q + AW'(1)) : (idx_q - AW'(1));
        mem_req_o.wdata = rdata_i;
      end
      S_PUT: begin
        mem_req_o.we = 1'b1;
      end
      S_GET: begin
        mem_req_o.raddr = ip_q;
      end
      S_HEAD: begin
        mem_req_o.raddr = '0;
      end
      S_TAIL, S_FIN: begin
        mem_req_o.raddr = last_idx;
      end
      default: begin
      end
    endcase
    res_o.valid      = (state_q == S_FIN);
    res_o.read_value = rd_q;
    res_o.status     = st_q;
    res_o.count      = CNT_OUT_W'(cnt_q);
    res_o.head_value = empty ? '0 : head_q;
    res_o.tail_value = empty ? '0 : rdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    lim_q  <= lim_d;
    ip_q   <= ip_d;
    up_q   <= up_d;
    get_q  <= get_d;
    st_q   <= st_d;
    val_q  <= val_d;
    rd_q   <= rd_d;
    head_q <= head_d;
  end

endmodule

`default_nettype wire

>>> dv/indexed_list_store_test.sv
module indexed_list_store_test;
  import ils_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NOP_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_NOP_HI = 4'd15;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [POS_W-1:0]     position;
    logic signed [DW-1:0] item_value;
  } list_op_t;

  typedef struct packed {
    logic signed [DW-1:0] read_value;
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
    logic signed [DW-1:0] head_value;
    logic signed [DW-1:0] tail_value;
  } list_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         func_r = '0;
  logic [POS_W-1:0]          pos_r = '0;
  logic signed [DW-1:0]      val_r = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [DW-1:0]      read_value;
  logic [1:0]                status;
  logic [CNT_OUT_W-1:0]      count;
  logic signed [DW-1:0]      head_value;
  logic signed [DW-1:0]      tail_value;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  logic signed [DW-1:0] shadow_list[DEPTH];
  int shadow_n = 0;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  indexed_list_store DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func_r),
    .position_i  (pos_r),
    .item_value_i(val_r),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .read_value_o(read_value),
    .status_o    (status),
    .count_o     (count),
    .head_value_o(head_value),
    .tail_value_o(tail_value)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  function automatic void shadow_put(int pos, logic signed [DW-1:0] v);
    for (int i = shadow_n; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = v;
    shadow_n++;
  endfunction

  function automatic void shadow_take(int pos);
    for (int i = pos; i < shadow_n - 1; i++) shadow_list[i] = shadow_list[i+1];
    shadow_n--;
  endfunction

  function automatic list_result_t predict_list_op(list_op_t op);
    list_result_t res;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op.func)
      FN_PREPEND, FN_APPEND: begin
        if (shadow_n >= DEPTH) res.status = ST_FULL;
        else shadow_put(op.func == FN_PREPEND ? 0 : shadow_n, op.item_value);
      end
      FN_DELFIRST, FN_DELLAST: begin
        if (shadow_n == 0) res.status = ST_EMPTY;
        else shadow_take(op.func == FN_DELFIRST ? 0 : shadow_n - 1);
      end
      FN_GET, FN_SET: begin
        if (shadow_n == 0) res.status = ST_EMPTY;
        else if (int'(op.position) >= shadow_n) res.status = ST_OOB;
        else if (op.func == FN_GET) res.read_value = shadow_list[op.position];
        else shadow_list[op.position] = op.item_value;
      end
      FN_INSERT: begin
        if (int'(op.position) > shadow_n) res.status = ST_OOB;
        else if (shadow_n >= DEPTH) res.status = ST_FULL;
        else shadow_put(int'(op.position), op.item_value);
      end
      FN_REMOVE: begin
        if (int'(op.position) >= shadow_n) res.status = ST_OOB;
        else shadow_take(int'(op.position));
      end
      FN_CLEAR: shadow_n = 0;
      default: ;
    endcase
    res.count = CNT_OUT_W'(shadow_n);
    if (shadow_n != 0) begin
      res.head_value = shadow_list[0];
      res.tail_value = shadow_list[shadow_n-1];
    end else begin
      res.head_value = '0;
      res.tail_value = '0;
    end
    return res;
  endfunction

  function automatic int idle_pct(bit receiver);
    int third;
    third = (pending_ops.size() + accepted_cnt) / 3;
    if (accepted_cnt < third) return receiver ? 48 : 13;
    else if (accepted_cnt < 2 * third) return receiver ? 13 : 48;
    else return 0;
  endfunction

  function automatic list_op_t make_op(logic [FUNC_W-1:0] f, int p, logic [DW-1:0] v);
    list_op_t op;
    op.func       = f;
    op.position   = POS_W'(p);
    op.item_value = v;
    return op;
  endfunction

  function automatic logic [DW-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_position();
    if ($urandom_range(4) == 0) return $urandom_range(31);
    return $urandom_range(16);
  endfunction

  always @(posedge clk_i) begin : driver
    list_op_t next_op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_list_op(make_op(func_r, int'(pos_r), val_r)));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the word
      end else if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        next_op = pending_ops.pop_front();
        func_r   <= next_op.func;
        pos_r    <= next_op.position;
        val_r    <= next_op.item_value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    list_result_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("unexpected result: rd=%h st=%0d cnt=%0d hd=%h tl=%h",
                     read_value, status, count, head_value, tail_value);
          mismatch_cnt++;
        end else begin
          exp_res = expected_results.pop_front();
          if (read_value !== exp_res.read_value || status !== 2'(exp_res.status) ||
              count !== exp_res.count || head_value !== exp_res.head_value ||
              tail_value !== exp_res.tail_value) begin
            if (mismatch_cnt < MAX_REPORTS) begin
              $display("mismatch: exp rd=%h st=%0d cnt=%0d hd=%h tl=%h",
                       exp_res.read_value, exp_res.status, exp_res.count,
                       exp_res.head_value, exp_res.tail_value);
              $display("          got rd=%h st=%0d cnt=%0d hd=%h tl=%h",
                       read_value, status, count, head_value, tail_value);
            end
            mismatch_cnt++;
          end
        end
      end
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int added;
    int kind;
    // directed corner cases: empty list, out-of-range positions, unused codes, clear
    pending_ops.push_back(make_op(FN_DELFIRST, 0, 32'h1111_1111));
    pending_ops.push_back(make_op(FN_DELLAST, 0, 32'h2222_2222));
    pending_ops.push_back(make_op(FN_GET, 0, '0));
    pending_ops.push_back(make_op(FN_SET, 0, 32'h3333_3333));
    pending_ops.push_back(make_op(FN_REMOVE, 0, '0));
    pending_ops.push_back(make_op(FN_INSERT, 1, 32'h4444_4444));
    pending_ops.push_back(make_op(FN_INSERT, 0, 32'h7fff_ffff));
    pending_ops.push_back(make_op(FN_APPEND, 0, 32'h8000_0000));
    pending_ops.push_back(make_op(FN_PREPEND, 31, 32'hffff_ffff));
    pending_ops.push_back(make_op(FN_GET, 31, '0));
    pending_ops.push_back(make_op(FN_GET, 2, '0));
    pending_ops.push_back(make_op(FN_SET, 1, '0));
    pending_ops.push_back(make_op(FN_INSERT, 3, 32'h1234_5678));
    pending_ops.push_back(make_op(FN_INSERT, 1, 32'ha5a5_a5a5));
    pending_ops.push_back(make_op(FN_GET, 1, '0));
    pending_ops.push_back(make_op(FN_REMOVE, 2, '0));
    pending_ops.push_back(make_op(FN_REMOVE, 31, '0));
    pending_ops.push_back(make_op(FN_DELFIRST, 0, '0));
    pending_ops.push_back(make_op(FN_DELLAST, 0, '0));
    pending_ops.push_back(make_op(FN_NOP_LO, 0, 32'h5a5a_5a5a));
    pending_ops.push_back(make_op(FN_NOP_HI, 31, '1));
    pending_ops.push_back(make_op(FN_CLEAR, 0, '0));
    pending_ops.push_back(make_op(FN_GET, 0, '0));
    pending_ops.push_back(make_op(FN_REMOVE, 0, '0));

    added = 0;
    while (added < RANDOM_ITEMS) begin
      kind = $urandom_range(9);
      if (kind <= 1) begin
        // fill past full
        for (int i = 0; i < 19; i++) begin
          case ($urandom_range(2))
            0: pending_ops.push_back(make_op(FN_PREPEND, rand_position(), rand_value()));
            1: pending_ops.push_back(make_op(FN_APPEND, rand_position(), rand_value()));
            default: pending_ops.push_back(make_op(FN_INSERT, $urandom_range(4), rand_value()));
          endcase
        end
        pending_ops.push_back(make_op(FN_INSERT, $urandom_range(20), rand_value()));
        added += 20;
      end else if (kind <= 3) begin
        // drain past empty
        for (int i = 0; i < 19; i++) begin
          case ($urandom_range(2))
            0: pending_ops.push_back(make_op(FN_DELFIRST, rand_position(), rand_value()));
            1: pending_ops.push_back(make_op(FN_DELLAST, rand_position(), rand_value()));
            default: pending_ops.push_back(make_op(FN_REMOVE, $urandom_range(3), rand_value()));
          endcase
        end
        added += 19;
      end else if (kind <= 8) begin
        for (int i = 0; i < 20; i++) begin
          if ($urandom_range(19) == 0)
            pending_ops.push_back(make_op(FUNC_W'($urandom_range(FN_NOP_LO, FN_NOP_HI)),
                                          $urandom_range(31), $urandom));
          else
            pending_ops.push_back(make_op(FUNC_W'($urandom_range(FN_PREPEND, FN_REMOVE)),
                                          rand_position(), rand_value()));
        end
        added += 20;
      end else begin
        pending_ops.push_back(make_op(FN_CLEAR, $urandom_range(31), $urandom));
        pending_ops.push_back(make_op(FUNC_W'($urandom_range(FN_DELFIRST, FN_REMOVE)),
                                      $urandom_range(31), $urandom));
        added += 2;
      end
    end

    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ils_pkg.sv
design/ils_ram.sv
design/ils_ctrl.sv
design/indexed_list_store.sv
dv/indexed_list_store_test.sv
